/* hw/rtl/lpcsr_pkg.sv */
// lpcsr_pkg: shared constants, codes, types and helper functions for the
// lpc sample reconstruction block and its iterative divider
// no dependencies
package lpcsr_pkg;

	localparam int DEF_MAX_TAPS       = 256;
	localparam int DEF_RUN_COUNT_BITS = 16;

	localparam int DATA_W   = 32;
	localparam int COEFF_W  = 28;
	localparam int QUANT_W  = 4;

	localparam int PRED_BIAS       = 16;
	localparam int PRED_EARLY_TAPS = 15;
	localparam int PRED_SHIFT      = 6;

	localparam int SAMPLE_HI_W = 16;
	localparam int SAMPLE_LO_W = 8;

	localparam int VRQ_START_SHIFT = 2;
	localparam int VRQ_MAX_LEVEL   = 8;
	localparam int VRQ_LEVEL_BIAS  = 7;
	localparam int QUANT_MAX       = 15;
	localparam int RUN_SUM_SHIFT   = 6;

	localparam int DIV_STEPS = 32;
	localparam int BITLEN_W  = $clog2(DIV_STEPS + 1);

	// request codes
	localparam logic [1:0] REQ_LOAD_TAP = 2'd0;
	localparam logic [1:0] REQ_START    = 2'd1;
	localparam logic [1:0] REQ_RESIDUAL = 2'd2;
	localparam logic [1:0] REQ_CLEAR    = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUANT_INIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VRQ_LEVEL  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_16  = 2'd2;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [BITLEN_W-1:0] bitlen;
	} div_stat_t;

	function automatic logic [QUANT_W-1:0] eff_level(input logic [QUANT_W-1:0] lvl);
		if (lvl > QUANT_W'(VRQ_MAX_LEVEL)) begin
			return QUANT_W'(VRQ_MAX_LEVEL);
		end
		return lvl;
	endfunction

	function automatic logic [QUANT_W-1:0] load_quant(input logic [QUANT_W-1:0] init,
		input logic [QUANT_W-1:0] lvl);
		if (eff_level(lvl) != '0) begin
			return QUANT_W'(VRQ_START_SHIFT);
		end
		return init;
	endfunction

	// lowest adapted shift for each level
	function automatic logic [QUANT_W-1:0] vrq_floor(input logic [QUANT_W-1:0] lvl);
		case (lvl) inside
			[4'd1:4'd2]: return QUANT_W'(3);
			[4'd3:4'd4]: return QUANT_W'(2);
			default:     return QUANT_W'(1);
		endcase
	endfunction

endpackage

/* hw/rtl/lpcsr_div.sv */
// lpcsr_div: restoring divider, one quotient bit per cycle, that reports the
// bit length of the quotient rather than the quotient itself
// depends on lpcsr_pkg
module lpcsr_div #(
	parameter int DIVISOR_W = lpcsr_pkg::DEF_RUN_COUNT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpcsr_pkg::DATA_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]          divisor,
	output lpcsr_pkg::div_stat_t          stat
);
	import lpcsr_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DATA_W-1:0]    dvd_q;
	logic [BITLEN_W-1:0]  bitlen_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   trial_sub;
	logic                 ge;

	assign trial     = {rem_q, dvd_q[DATA_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign ge        = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= '0;
			dvd_q    <= dividend;
			dsr_q    <= divisor;
			bitlen_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			// first set quotient bit fixes the bit length
			if (ge && bitlen_q == '0) begin
				bitlen_q <= BITLEN_W'(DIV_STEPS) - BITLEN_W'(step_q);
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.bitlen = bitlen_q;

endmodule

/* hw/rtl/lpc_sample_reconstruction.sv */
// lpc_sample_reconstruction: lpc synthesis filter with a shared multiply-accumulate,
// history ring buffer, lossless integration, clipping and quantizer adaptation
// depends on lpcsr_pkg and lpcsr_div
//
//  channel  direction  handshake            beat contents
//  cfg      in         cfg_we               cfg_index, cfg_data
//  in       in         in_valid / in_stall  req_type .. run_end
//  out      out        out_valid / out_stall sample, quant_shift
//
// load tap, start filter and clear history are finished in the idle state
// a residual is set by the single multiply-accumulate walking the taps one per cycle,
// then runs the lossless or the quantized steps
// a run end with adaptation adds a pass through the bit-serial divider
// in_stall is high while a residual is in work, including a wait on a full output register
// arst_n empties the history and run counters and reloads the register defaults; taps are kept
module lpc_sample_reconstruction #(
	parameter int MAX_TAPS       = lpcsr_pkg::DEF_MAX_TAPS,
	parameter int RUN_COUNT_BITS = lpcsr_pkg::DEF_RUN_COUNT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lpcsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lpcsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic [7:0]                           coeff_index,
	input  logic signed [lpcsr_pkg::COEFF_W-1:0] coeff_value,
	input  logic [8:0]                           tap_count,
	input  logic [3:0]                           frac_shift,
	input  logic signed [lpcsr_pkg::DATA_W-1:0]  residual,
	input  logic                                 run_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lpcsr_pkg::DATA_W-1:0]  sample,
	output logic [lpcsr_pkg::QUANT_W-1:0]        quant_shift
);
	import lpcsr_pkg::*;

	localparam int TAP_AW = $clog2(MAX_TAPS);
	localparam int CNT_W  = $clog2(MAX_TAPS + 1);
	localparam logic [TAP_AW-1:0] LAST_PTR = TAP_AW'(MAX_TAPS - 1);
	localparam logic [CNT_W-1:0]  TAPS_FULL = CNT_W'(MAX_TAPS);
	localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};
	localparam logic [DATA_W-1:0] ACC_INIT = DATA_W'(PRED_BIAS * 2);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
	localparam logic [ST_W-1:0] ST_MAC    = 5'd1;
	localparam logic [ST_W-1:0] ST_PRED   = 5'd2;
	localparam logic [ST_W-1:0] ST_L1     = 5'd3;
	localparam logic [ST_W-1:0] ST_L2     = 5'd4;
	localparam logic [ST_W-1:0] ST_L3     = 5'd5;
	localparam logic [ST_W-1:0] ST_Q1     = 5'd6;
	localparam logic [ST_W-1:0] ST_Q2     = 5'd7;
	localparam logic [ST_W-1:0] ST_Q3     = 5'd8;
	localparam logic [ST_W-1:0] ST_Q4     = 5'd9;
	localparam logic [ST_W-1:0] ST_Q5     = 5'd10;
	localparam logic [ST_W-1:0] ST_Q6     = 5'd11;
	localparam logic [ST_W-1:0] ST_COMMIT = 5'd12;
	localparam logic [ST_W-1:0] ST_DIVGO  = 5'd13;
	localparam logic [ST_W-1:0] ST_DIV    = 5'd14;
	localparam logic [ST_W-1:0] ST_ADAPT  = 5'd15;
	localparam logic [ST_W-1:0] ST_OUT    = 5'd16;

	// configuration and filter state
	logic [QUANT_W-1:0]        qinit_q;
	logic [QUANT_W-1:0]        vrq_q;
	logic                      is16_q;
	logic [QUANT_W-1:0]        quant_q;
	logic [CNT_W-1:0]          active_q;
	logic [3:0]                lowsh_q;
	logic [DATA_W-1:0]         prev_q;
	logic [DATA_W-1:0]         run_sum_q;
	logic [RUN_COUNT_BITS-1:0] run_len_q;
	logic [TAP_AW-1:0]         head_q;
	logic [CNT_W-1:0]          fill_q;

	// sequencer
	logic [ST_W-1:0]   state_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TAP_AW-1:0] ptr_q;

	// working registers
	logic [DATA_W-1:0] val_q;
	logic              run_end_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] h0_q;
	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] outv_q;
	logic [DATA_W-1:0] diff_q;

	// mac pipeline
	logic               v_s1, use_s1, early_s1, hv_s1, first_s1;
	logic [COEFF_W-1:0] coef_s1;
	logic [DATA_W-1:0]  hist_s1;
	logic               v_s2, use_s2, early_s2;
	logic [DATA_W-1:0]  prod_s2;

	// memories
	logic [COEFF_W-1:0] tap_mem  [MAX_TAPS];
	logic [DATA_W-1:0]  hist_mem [MAX_TAPS];

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  sample_q;
	logic [QUANT_W-1:0] qs_q;

	logic               in_acc;
	logic               issue;
	logic [TAP_AW-1:0]  ptr_inc;
	logic [TAP_AW-1:0]  head_dec;
	logic [DATA_W-1:0]  coef_ext;
	logic [DATA_W-1:0]  pred_lo;
	logic [DATA_W-1:0]  low_mask;
	logic [DATA_W-1:0]  clip_v;
	logic               in_range;
	logic               out_free;
	logic               div_start;
	div_stat_t          div_stat;
	logic [QUANT_W-1:0] lvl;
	logic [QUANT_W-1:0] lvl_floor;
	logic signed [7:0]  adj;
	logic [QUANT_W-1:0] adapt_q;

	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign issue    = (state_q == ST_MAC) && ((idx_q < active_q) || (idx_q == '0));
	assign ptr_inc  = (ptr_q == LAST_PTR) ? '0 : ptr_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_PTR : head_q - 1'b1;
	assign coef_ext = {{(DATA_W - COEFF_W){coef_s1[COEFF_W-1]}}, coef_s1};
	assign pred_lo  = $signed(acc_q) >>> lowsh_q;
	assign low_mask = (DATA_W'(1) << lowsh_q) - DATA_W'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign div_start = state_q == ST_DIVGO;

	// saturate to the sample width
	always_comb begin
		if (is16_q) begin
			in_range = (&t_q[DATA_W-1:SAMPLE_HI_W-1]) || !(|t_q[DATA_W-1:SAMPLE_HI_W-1]);
			clip_v   = {{(DATA_W - SAMPLE_HI_W + 1){t_q[DATA_W-1]}},
				{(SAMPLE_HI_W - 1){~t_q[DATA_W-1]}}};
		end else begin
			in_range = (&t_q[DATA_W-1:SAMPLE_LO_W-1]) || !(|t_q[DATA_W-1:SAMPLE_LO_W-1]);
			clip_v   = {{(DATA_W - SAMPLE_LO_W + 1){t_q[DATA_W-1]}},
				{(SAMPLE_LO_W - 1){~t_q[DATA_W-1]}}};
		end
	end

	// quantizer shift from the quotient bit length
	always_comb begin
		lvl       = eff_level(vrq_q);
		lvl_floor = vrq_floor(lvl);
		adj       = 8'(div_stat.bitlen) - 8'(lvl) - 8'(VRQ_LEVEL_BIAS);
		if (adj < $signed(8'(lvl_floor))) begin
			adapt_q = lvl_floor;
		end else if (adj > $signed(8'(QUANT_MAX))) begin
			adapt_q = QUANT_W'(QUANT_MAX);
		end else begin
			adapt_q = adj[QUANT_W-1:0];
		end
	end

	lpcsr_div #(
		.DIVISOR_W (RUN_COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({run_sum_q[DATA_W-RUN_SUM_SHIFT-1:0], {RUN_SUM_SHIFT{1'b0}}}),
		.divisor  (run_len_q),
		.stat     (div_stat)
	);

	// tap table
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_LOAD_TAP && int'(coeff_index) < MAX_TAPS) begin
			tap_mem[TAP_AW'(coeff_index)] <= coeff_value;
		end
		if (issue) begin
			coef_s1 <= tap_mem[idx_q[TAP_AW-1:0]];
		end
	end

	// difference history ring, newest at head
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			hist_mem[head_dec] <= diff_q;
		end
		if (issue) begin
			hist_s1 <= hist_mem[ptr_q];
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			ptr_q     <= '0;
			qinit_q   <= '0;
			vrq_q     <= '0;
			is16_q    <= 1'b1;
			quant_q   <= '0;
			active_q  <= '0;
			lowsh_q   <= '0;
			prev_q    <= '0;
			run_sum_q <= '0;
			run_len_q <= '0;
			head_q    <= '0;
			fill_q    <= '0;
			v_s1      <= 1'b0;
			use_s1    <= 1'b0;
			early_s1  <= 1'b0;
			hv_s1     <= 1'b0;
			first_s1  <= 1'b0;
			v_s2      <= 1'b0;
			use_s2    <= 1'b0;
			early_s2  <= 1'b0;
		end else begin
			v_s1     <= issue;
			use_s1   <= idx_q < active_q;
			early_s1 <= idx_q < CNT_W'(PRED_EARLY_TAPS);
			hv_s1    <= idx_q < fill_q;
			first_s1 <= idx_q == '0;
			v_s2     <= v_s1;
			use_s2   <= use_s1;
			early_s2 <= early_s1;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (req_type)
							REQ_START: begin
								active_q  <= (int'(tap_count) > MAX_TAPS) ?
									TAPS_FULL : CNT_W'(tap_count);
								lowsh_q   <= (quant_q == '0) ? frac_shift : '0;
								run_sum_q <= '0;
								run_len_q <= '0;
							end
							REQ_CLEAR: begin
								fill_q    <= '0;
								prev_q    <= '0;
								run_sum_q <= '0;
								run_len_q <= '0;
							end
							REQ_RESIDUAL: begin
								idx_q   <= '0;
								ptr_q   <= head_q;
								state_q <= ST_MAC;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MAC: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
						ptr_q <= ptr_inc;
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_PRED;
					end
				end
				ST_PRED: state_q <= (quant_q == '0) ? ST_L1 : ST_Q1;
				ST_L1:   state_q <= ST_L2;
				ST_L2:   state_q <= ST_L3;
				ST_L3:   state_q <= ST_COMMIT;
				ST_Q1:   state_q <= ST_Q2;
				ST_Q2:   state_q <= ST_Q3;
				ST_Q3:   state_q <= ST_Q4;
				ST_Q4:   state_q <= ST_Q5;
				ST_Q5:   state_q <= ST_Q6;
				ST_Q6: begin
					run_sum_q <= run_sum_q + t_q;
					state_q   <= ST_COMMIT;
				end
				ST_COMMIT: begin
					head_q <= head_dec;
					prev_q <= outv_q;
					if (fill_q != TAPS_FULL) begin
						fill_q <= fill_q + 1'b1;
					end
					if (run_len_q != RUN_MAX) begin
						run_len_q <= run_len_q + 1'b1;
					end
					if (run_end_q && lvl != '0) begin
						state_q <= ST_DIVGO;
					end else begin
						if (run_end_q) begin
							run_sum_q <= '0;
							run_len_q <= '0;
						end
						state_q <= ST_OUT;
					end
				end
				ST_DIVGO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_ADAPT;
					end
				end
				ST_ADAPT: begin
					quant_q   <= adapt_q;
					run_sum_q <= '0;
					run_len_q <= '0;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_we) begin
				case (cfg_index)
					CFG_QUANT_INIT: begin
						qinit_q <= cfg_data;
						quant_q <= load_quant(cfg_data, vrq_q);
					end
					CFG_VRQ_LEVEL: begin
						vrq_q   <= cfg_data;
						quant_q <= load_quant(qinit_q, cfg_data);
					end
					CFG_SAMPLE_16: is16_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s2 <= hv_s1 ? coef_ext * hist_s1 : '0;
		if (v_s1 && first_s1) begin
			h0_q <= hv_s1 ? hist_s1 : '0;
		end
		if (v_s2 && use_s2) begin
			acc_q <= acc_q + (early_s2 ? {prod_s2[DATA_W-2:0], 1'b0} : prod_s2);
		end
		case (state_q)
			ST_IDLE: begin
				if (in_acc && req_type == REQ_RESIDUAL) begin
					val_q     <= residual;
					run_end_q <= run_end;
					acc_q     <= ACC_INIT;
				end
			end
			ST_PRED: acc_q  <= $signed(acc_q) >>> PRED_SHIFT;
			ST_L1:   t_q    <= val_q + pred_lo;
			ST_L2:   diff_q <= (t_q << lowsh_q) | (h0_q & low_mask);
			ST_L3:   outv_q <= diff_q + prev_q;
			ST_Q1:   t_q    <= acc_q + prev_q;
			ST_Q2:   t_q    <= t_q + (val_q << quant_q);
			ST_Q3:   outv_q <= in_range ? t_q : clip_v;
			ST_Q4:   diff_q <= outv_q - prev_q;
			ST_Q5:   t_q    <= diff_q[DATA_W-1] ? (DATA_W'(0) - diff_q) : diff_q;
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			sample_q <= outv_q;
			qs_q     <= quant_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign quant_shift = qs_q;

`ifndef SYNTHESIS
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result beat raised outside the hand-over step");

	a_cmd_single: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req_type != REQ_RESIDUAL) |=> state_q == ST_IDLE)
		else $error("non-residual request left the sequencer busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= TAPS_FULL)
		else $error("history fill count beyond tap capacity");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_mac_contained: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == ST_MAC)
		else $error("mac pipeline beat outside the tap walk");

	a_adapt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADAPT |=> quant_q != '0)
		else $error("adapted quantizer shift fell to lossless");
`endif

endmodule
